>>> rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// shared concurrent assertion macros for the console checker
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define TCW_ASSERT_IMPLY(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define TCW_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> rtl/tcw_pkg.sv
// ----------------------------------------------------------------------------
// tcw_pkg
// shared types, codes and defaults of the text console writer
// ----------------------------------------------------------------------------
package tcw_pkg;

   localparam int SCREEN_COLUMNS_DEFAULT = 80;
   localparam int SCREEN_ROWS_DEFAULT    = 25;

   localparam logic [7:0] BLANK_CHAR   = 8'h20;
   localparam logic [7:0] NEWLINE_CHAR = 8'h0A;

   // request kinds carried on req_tuser
   localparam logic [1:0] REQ_PUT   = 2'd0;
   localparam logic [1:0] REQ_CLEAR = 2'd1;
   localparam logic [1:0] REQ_GOTO  = 2'd2;
   localparam logic [1:0] REQ_READ  = 2'd3;

   localparam int REQ_TDATA_W = 40;
   localparam int RSP_TDATA_W = 32;
   localparam int CELL_ADDR_W = 11;
   localparam int ROW_OUT_W   = 5;
   localparam int COL_OUT_W   = 7;

   typedef struct packed {
      logic [7:0] color;
      logic [7:0] char_code;
   } cell_type;

endpackage

>>> rtl/tcw_screen_ram.sv
// ----------------------------------------------------------------------------
// tcw_screen_ram
// screen cell store, one write and one registered read port
// ----------------------------------------------------------------------------
module tcw_screen_ram
   import tcw_pkg::*;
#(
   parameter int DEPTH = SCREEN_COLUMNS_DEFAULT * SCREEN_ROWS_DEFAULT,
   parameter int AW    = $clog2(DEPTH)
) (
   input  logic          clock,
   input  logic          wr_en,
   input  logic [AW-1:0] wr_addr,
   input  cell_type      wr_data,
   input  logic          rd_en,
   input  logic [AW-1:0] rd_addr,
   output cell_type      rd_data
);

   cell_type screen_mem [DEPTH];
   cell_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         screen_mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= screen_mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> rtl/text_console_writer.sv
// ----------------------------------------------------------------------------
// text_console_writer
// text console holding a screen of character and attribute cells and a cursor
// ----------------------------------------------------------------------------
// A request that stays on the cursor or a single cell passes through the
// exec and finish states: putting a character, a newline or go to line that
// does not scroll, and a cell read. Clear writes every cell once.
// A scroll copies the screen up one row through the single read and single
// write port of the cell memory and blanks the last row; a character that
// caused it is then written in a second pass through the exec state.
// A result may wait on rsp_tready while the next request is accepted.
module text_console_writer
   import tcw_pkg::*;
#(
   parameter int SCREEN_COLUMNS = SCREEN_COLUMNS_DEFAULT,
   parameter int SCREEN_ROWS    = SCREEN_ROWS_DEFAULT
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   // character [7:0], color [15:8], line [23:16], cell_addr [34:24]
   input  logic [REQ_TDATA_W-1:0] req_tdata,
   // req_type [1:0]
   input  logic [1:0]             req_tuser,
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   // cursor_row [4:0], cursor_col [11:5], read_char [19:12], read_color [27:20]
   output logic [RSP_TDATA_W-1:0] rsp_tdata
);

   localparam int CELL_COUNT = SCREEN_ROWS * SCREEN_COLUMNS;
   localparam int IW = $clog2(CELL_COUNT);
   localparam int PW = $clog2(CELL_COUNT + 1);
   localparam int RW = $clog2(SCREEN_ROWS + 1);
   localparam int CW = $clog2(SCREEN_COLUMNS);

   localparam logic [PW-1:0] CELL_END   = PW'(CELL_COUNT);
   localparam logic [PW-1:0] COPY_START = PW'(SCREEN_COLUMNS);
   localparam logic [IW-1:0] LAST_IDX   = IW'(CELL_COUNT - 1);
   localparam logic [RW-1:0] ROW_LAST   = RW'(SCREEN_ROWS - 1);
   localparam logic [RW-1:0] ROW_END    = RW'(SCREEN_ROWS);
   localparam logic [CW-1:0] COL_LAST   = CW'(SCREEN_COLUMNS - 1);
   localparam logic [7:0]    LINE_END   = 8'(SCREEN_ROWS);

   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_EXEC   = 3'd1;
   localparam logic [2:0] ST_SCROLL = 3'd2;
   localparam logic [2:0] ST_CLEAR  = 3'd3;
   localparam logic [2:0] ST_FINISH = 3'd4;

   logic [2:0]             state_ff, state_in;
   logic [RW-1:0]          row_ff, row_in;
   logic [CW-1:0]          col_ff, col_in;
   logic [PW-1:0]          rd_ptr_ff, rd_ptr_in;
   logic [IW-1:0]          wr_ptr_ff, wr_ptr_in;
   logic                   copy_vld_ff, copy_vld_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [RSP_TDATA_W-1:0] rsp_data_ff, rsp_data_in;

   logic [1:0]             type_ff;
   logic [7:0]             char_ff, color_ff, line_ff;
   logic [CELL_ADDR_W-1:0] addr_ff;

   logic                   req_fire, slot_free, rd_issue, addr_ok;
   logic [CELL_ADDR_W-1:0] req_addr;
   logic [IW-1:0]          cur_idx;
   cell_type               blank_cell, rd_data, wr_data;
   logic                   wr_en, rd_en;
   logic [IW-1:0]          wr_addr, rd_addr;

   assign slot_free  = !rsp_valid_ff || rsp_tready;
   assign req_tready = (state_ff == ST_IDLE) || (state_ff == ST_FINISH && slot_free);
   assign req_fire   = req_tvalid && req_tready;
   assign req_addr   = req_tdata[34:24];
   assign rd_issue   = rd_ptr_ff != CELL_END;
   assign addr_ok    = 32'(addr_ff) < 32'(CELL_COUNT);
   assign cur_idx    = IW'(row_ff) * IW'(SCREEN_COLUMNS) + IW'(col_ff);
   assign blank_cell = '{color: color_ff, char_code: BLANK_CHAR};

   // memory read port: cell read on transfer, copy reads while scrolling
   always_comb begin
      if (state_ff == ST_SCROLL) begin
         rd_en   = rd_issue;
         rd_addr = IW'(rd_ptr_ff);
      end else begin
         rd_en   = req_fire && req_tuser == REQ_READ &&
                   32'(req_addr) < 32'(CELL_COUNT);
         rd_addr = IW'(req_addr);
      end
   end

   always_comb begin
      state_in     = state_ff;
      row_in       = row_ff;
      col_in       = col_ff;
      rd_ptr_in    = rd_ptr_ff;
      wr_ptr_in    = wr_ptr_ff;
      copy_vld_in  = 1'b0;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      wr_en        = 1'b0;
      wr_addr      = wr_ptr_ff;
      wr_data      = blank_cell;

      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            state_in  = ST_FINISH;
            rd_ptr_in = COPY_START;
            wr_ptr_in = '0;
            case (type_ff)
               REQ_PUT: begin
                  if (char_ff == NEWLINE_CHAR) begin
                     if (row_ff >= ROW_LAST) begin
                        state_in = ST_SCROLL;
                     end else begin
                        row_in = row_ff + 1'b1;
                        col_in = '0;
                     end
                  end else if (row_ff == ROW_END) begin
                     state_in = ST_SCROLL;
                  end else begin
                     wr_en   = 1'b1;
                     wr_addr = cur_idx;
                     wr_data = '{color: color_ff, char_code: char_ff};
                     if (col_ff == COL_LAST) begin
                        row_in = row_ff + 1'b1;
                        col_in = '0;
                     end else begin
                        col_in = col_ff + 1'b1;
                     end
                  end
               end
               REQ_CLEAR: begin
                  state_in = ST_CLEAR;
               end
               REQ_GOTO: begin
                  if (line_ff >= LINE_END) begin
                     state_in = ST_SCROLL;
                  end else begin
                     row_in = RW'(line_ff);
                     col_in = '0;
                  end
               end
               default: begin
               end
            endcase
         end
         ST_SCROLL: begin
            // read one row ahead, write each copy in the cycle after its read, then blank
            copy_vld_in = rd_issue;
            if (rd_issue) begin
               rd_ptr_in = rd_ptr_ff + 1'b1;
            end
            wr_en   = copy_vld_ff || !rd_issue;
            wr_data = copy_vld_ff ? rd_data : blank_cell;
            if (wr_en) begin
               wr_ptr_in = wr_ptr_ff + 1'b1;
            end
            if (!rd_issue && !copy_vld_ff && wr_ptr_ff == LAST_IDX) begin
               row_in = ROW_LAST;
               col_in = '0;
               if (type_ff == REQ_PUT && char_ff != NEWLINE_CHAR) begin
                  state_in = ST_EXEC;
               end else begin
                  state_in = ST_FINISH;
               end
            end
         end
         ST_CLEAR: begin
            wr_en     = 1'b1;
            wr_ptr_in = wr_ptr_ff + 1'b1;
            if (wr_ptr_ff == LAST_IDX) begin
               row_in   = '0;
               col_in   = '0;
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (slot_free) begin
               rsp_valid_in        = 1'b1;
               rsp_data_in         = '0;
               rsp_data_in[4:0]    = ROW_OUT_W'(row_ff);
               rsp_data_in[11:5]   = COL_OUT_W'(col_ff);
               if (type_ff == REQ_READ && addr_ok) begin
                  rsp_data_in[19:12] = rd_data.char_code;
                  rsp_data_in[27:20] = rd_data.color;
               end
               state_in = req_fire ? ST_EXEC : ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         row_ff       <= '0;
         col_ff       <= '0;
         copy_vld_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         row_ff       <= row_in;
         col_ff       <= col_in;
         copy_vld_ff  <= copy_vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rd_ptr_ff   <= rd_ptr_in;
      wr_ptr_ff   <= wr_ptr_in;
      rsp_data_ff <= rsp_data_in;
      if (req_fire) begin
         type_ff  <= req_tuser;
         char_ff  <= req_tdata[7:0];
         color_ff <= req_tdata[15:8];
         line_ff  <= req_tdata[23:16];
         addr_ff  <= req_addr;
      end
   end

   tcw_screen_ram #(
      .DEPTH (CELL_COUNT),
      .AW    (IW)
   ) u_screen_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

>>> rtl/tcw_checker.sv
// ----------------------------------------------------------------------------
// tcw_checker
// port-level checks of the text console writer, bound to the top level
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module tcw_checker
   import tcw_pkg::*;
#(
   parameter int SCREEN_COLUMNS = SCREEN_COLUMNS_DEFAULT,
   parameter int SCREEN_ROWS    = SCREEN_ROWS_DEFAULT
) (
   input logic                   clock,
   input logic                   reset,
   input logic                   req_tvalid,
   input logic                   req_tready,
   input logic                   rsp_tvalid,
   input logic                   rsp_tready,
   input logic [RSP_TDATA_W-1:0] rsp_tdata
);

   `TCW_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready,
      rsp_tvalid, "result dropped while stalled")
   `TCW_ASSERT_NEXT(a_rsp_stable, clock, reset, rsp_tvalid && !rsp_tready,
      $stable(rsp_tdata), "stalled result changed")
   `TCW_ASSERT_NEXT(a_busy_after_req, clock, reset, req_tvalid && req_tready,
      !req_tready, "request taken while busy")
   `TCW_ASSERT_IMPLY(a_col_range, clock, reset, rsp_tvalid,
      32'(rsp_tdata[11:5]) < 32'(SCREEN_COLUMNS), "cursor column out of range")
   `TCW_ASSERT_IMPLY(a_full_col, clock, reset,
      rsp_tvalid && SCREEN_ROWS < 32 && 32'(rsp_tdata[4:0]) == 32'(SCREEN_ROWS),
      rsp_tdata[11:5] == 7'd0, "full screen cursor not at column zero")

endmodule

bind text_console_writer tcw_checker #(
   .SCREEN_COLUMNS (SCREEN_COLUMNS),
   .SCREEN_ROWS    (SCREEN_ROWS)
) u_tcw_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

>>> tb/text_console_writer_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// text_console_writer_tb
// self-checking bench for the text console writer: a scoreboard keeps its own
// copy of the screen and cursor, predicts the status of every accepted
// request and checks each response transfer against it, under random stalls
// on both streams, a long response hold-off and scrolls reached by filling
// the bottom row
// ----------------------------------------------------------------------------
import tcw_pkg::*;

localparam int COLS  = SCREEN_COLUMNS_DEFAULT;
localparam int ROWS  = SCREEN_ROWS_DEFAULT;
localparam int CELLS = COLS * ROWS;
localparam int ADDR_MAX = (1 << CELL_ADDR_W) - 1;

typedef struct packed {
   logic [1:0]             kind;
   logic [7:0]             char_code;
   logic [7:0]             color;
   logic [7:0]             line;
   logic [CELL_ADDR_W-1:0] cell_addr;
} console_req_type;

typedef struct packed {
   logic [ROW_OUT_W-1:0] row;
   logic [COL_OUT_W-1:0] col;
   logic [7:0]           read_char;
   logic [7:0]           read_color;
} console_status_type;

class console_scoreboard;
   cell_type           screen [CELLS];
   bit                 written [CELLS];
   int                 cursor;
   console_status_type expected_status [$];
   int error_count;
   int result_count;
   int request_count;
   int read_count;
   int clear_count;
   int scroll_count;
   int full_count;

   function new();
      cursor = 0;
   endfunction

   function bit is_written(int addr);
      if (addr < 0 || addr >= CELLS) return 1'b0;
      return written[addr];
   endfunction

   task report_mismatch(string msg);
      $display("mismatch: %s", msg);
      error_count++;
   endtask

   function void scroll_screen(logic [7:0] color);
      for (int i = 0; i < CELLS - COLS; i++) begin
         screen[i]  = screen[i + COLS];
         written[i] = written[i + COLS];
      end
      for (int i = CELLS - COLS; i < CELLS; i++) begin
         screen[i]  = {color, BLANK_CHAR};
         written[i] = 1'b1;
      end
      cursor = (ROWS - 1) * COLS;
      scroll_count++;
   endfunction

   function void jump_to_row(int row, logic [7:0] color);
      if (row >= ROWS) scroll_screen(color);
      else cursor = row * COLS;
   endfunction

   function void note_request(console_req_type r);
      console_status_type st;
      st.read_char  = '0;
      st.read_color = '0;
      request_count++;
      case (r.kind)
         REQ_PUT: begin
            if (r.char_code == NEWLINE_CHAR) begin
               jump_to_row(cursor / COLS + 1, r.color);
            end else begin
               if (cursor / COLS >= ROWS) scroll_screen(r.color);
               if (cursor < CELLS) begin
                  screen[cursor]  = {r.color, r.char_code};
                  written[cursor] = 1'b1;
                  cursor++;
               end
            end
         end
         REQ_CLEAR: begin
            for (int i = 0; i < CELLS; i++) begin
               screen[i]  = {r.color, BLANK_CHAR};
               written[i] = 1'b1;
            end
            cursor = 0;
            clear_count++;
         end
         REQ_GOTO: begin
            jump_to_row(int'(r.line), r.color);
         end
         REQ_READ: begin
            read_count++;
            if (r.cell_addr < CELLS) begin
               st.read_char  = screen[r.cell_addr].char_code;
               st.read_color = screen[r.cell_addr].color;
            end
         end
         default: begin
         end
      endcase
      if (cursor == CELLS) full_count++;
      st.row = ROW_OUT_W'(cursor / COLS);
      st.col = COL_OUT_W'(cursor % COLS);
      expected_status.push_back(st);
   endfunction

   task check_result(logic [RSP_TDATA_W-1:0] d);
      console_status_type got;
      console_status_type want;
      got.row        = d[4:0];
      got.col        = d[11:5];
      got.read_char  = d[19:12];
      got.read_color = d[27:20];
      result_count++;
      if (expected_status.size() == 0) begin
         report_mismatch($sformatf("response %0d with nothing outstanding", result_count));
         return;
      end
      want = expected_status.pop_front();
      if (got.row !== want.row)
         report_mismatch($sformatf("response %0d cursor_row %0d, expected %0d",
                                   result_count, got.row, want.row));
      if (got.col !== want.col)
         report_mismatch($sformatf("response %0d cursor_col %0d, expected %0d",
                                   result_count, got.col, want.col));
      if (got.read_char !== want.read_char)
         report_mismatch($sformatf("response %0d read_char %h, expected %h",
                                   result_count, got.read_char, want.read_char));
      if (got.read_color !== want.read_color)
         report_mismatch($sformatf("response %0d read_color %h, expected %h",
                                   result_count, got.read_color, want.read_color));
   endtask
endclass

module text_console_writer_tb;

   localparam int HOLD_CYCLES     = 300;
   localparam int STALL_LIMIT     = 20000;
   localparam int SETTLE_CYCLES   = 50;
   localparam int ITEMS_PER_PHASE = 190;

   logic                   clock      = 1'b0;
   logic                   reset      = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [REQ_TDATA_W-1:0] req_tdata  = '0;
   logic [1:0]             req_tuser  = REQ_PUT;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [RSP_TDATA_W-1:0] rsp_tdata;

   int   send_idle_pct = 0;
   int   recv_idle_pct = 0;
   logic hold_toggle   = 1'b0;
   logic hold_seen     = 1'b0;
   int   hold_left     = 0;

   console_scoreboard sb = new();

   always #4 clock = ~clock;

   text_console_writer dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   // response side: random stalls plus a long hold-off on request
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) sb.check_result(rsp_tdata);
         if (hold_toggle != hold_seen) begin
            hold_seen  <= hold_toggle;
            hold_left  <= HOLD_CYCLES;
            rsp_tready <= 1'b0;
         end else if (hold_left != 0) begin
            hold_left  <= hold_left - 1;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
         end
      end
   end

   initial begin
      int stall_cycles;
      stall_cycles = 0;
      while (stall_cycles < STALL_LIMIT) begin
         @(posedge clock);
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) stall_cycles = 0;
         else stall_cycles++;
      end
      $display("watchdog: no transfer for %0d cycles", STALL_LIMIT);
      $display("RESULT: ERROR");
      $finish;
   end

   task automatic send_request(input console_req_type r);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {r.cell_addr, r.line, r.color, r.char_code};
      req_tuser  <= r.kind;
      do @(posedge clock); while (!req_tready);
      sb.note_request(r);
   endtask

   task automatic issue(input logic [1:0] kind, input logic [7:0] char_code,
                        input logic [7:0] color, input logic [7:0] line,
                        input int addr);
      console_req_type r;
      r.kind      = kind;
      r.char_code = char_code;
      r.color     = color;
      r.line      = line;
      r.cell_addr = CELL_ADDR_W'(addr);
      send_request(r);
   endtask

   function automatic console_req_type random_fields();
      console_req_type r;
      r.kind      = REQ_PUT;
      r.char_code = 8'($urandom_range(0, 255));
      r.color     = 8'($urandom_range(0, 255));
      r.line      = 8'($urandom_range(0, 255));
      r.cell_addr = CELL_ADDR_W'($urandom_range(0, ADDR_MAX));
      return r;
   endfunction

   // only cells that hold a value, or addresses past the screen
   function automatic logic [CELL_ADDR_W-1:0] pick_read_addr();
      int a;
      if ($urandom_range(0, 99) < 8) return CELL_ADDR_W'($urandom_range(CELLS, ADDR_MAX));
      for (int t = 0; t < 20; t++) begin
         if ($urandom_range(0, 1) == 1 && sb.cursor > 0)
            a = sb.cursor - 1 - int'($urandom_range(0, 40));
         else
            a = int'($urandom_range(0, CELLS - 1));
         if (sb.is_written(a)) return CELL_ADDR_W'(a);
      end
      return CELL_ADDR_W'($urandom_range(CELLS, ADDR_MAX));
   endfunction

   task automatic send_random_item();
      console_req_type r;
      int pick;
      r    = random_fields();
      pick = $urandom_range(0, 99);
      if (pick < 45) begin
         r.kind = REQ_PUT;
         if ($urandom_range(0, 99) < 8) r.char_code = NEWLINE_CHAR;
      end else if (pick < 75) begin
         r.kind      = REQ_READ;
         r.cell_addr = pick_read_addr();
      end else if (pick < 96) begin
         r.kind = REQ_GOTO;
         if ($urandom_range(0, 99) < 80) r.line = 8'($urandom_range(0, ROWS - 1));
      end else begin
         r.kind = REQ_CLEAR;
      end
      send_request(r);
   endtask

   // jump to one of the two bottom rows and write characters that may run past the end of the screen
   task automatic run_fill_sequence();
      console_req_type r;
      int n;
      r      = random_fields();
      r.kind = REQ_GOTO;
      r.line = ($urandom_range(0, 3) == 0) ? 8'(ROWS - 2) : 8'(ROWS - 1);
      n      = $urandom_range(70, 100) + ((r.line == ROWS - 2) ? COLS : 0);
      send_request(r);
      for (int i = 0; i < n; i++) begin
         r      = random_fields();
         r.kind = REQ_PUT;
         send_request(r);
      end
      if ($urandom_range(0, 1) == 1) begin
         r           = random_fields();
         r.kind      = REQ_PUT;
         r.char_code = NEWLINE_CHAR;
         send_request(r);
      end
   endtask

   task automatic wait_for_drain();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (sb.expected_status.size() != 0);
   endtask

   task automatic run_phase(input int send_pct, input int recv_pct);
      int sent_before;
      send_idle_pct  = send_pct;
      recv_idle_pct <= recv_pct;
      sent_before    = sb.request_count;
      run_fill_sequence();
      while (sb.request_count - sent_before < ITEMS_PER_PHASE) begin
         if ($urandom_range(0, 99) < 1) run_fill_sequence();
         else send_random_item();
      end
      wait_for_drain();
   endtask

   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      send_idle_pct  = 32;
      recv_idle_pct <= 56;
      issue(REQ_PUT,   8'h00, 8'hFF, 8'h00, 0);
      issue(REQ_PUT,   8'hFF, 8'h00, 8'hFF, ADDR_MAX);
      issue(REQ_PUT,   8'h41, 8'h1E, 8'h18, 5);
      issue(REQ_READ,  8'h00, 8'h00, 8'h00, 0);
      issue(REQ_READ,  8'hFF, 8'hFF, 8'hFF, 2);
      // reads past the last cell
      issue(REQ_READ,  8'h0A, 8'h55, 8'h19, ADDR_MAX);
      issue(REQ_READ,  8'h20, 8'hAA, 8'h00, CELLS);
      issue(REQ_PUT,   NEWLINE_CHAR, 8'h5A, 8'h03, 0);
      issue(REQ_GOTO,  8'h41, 8'h00, 8'h00, 0);
      issue(REQ_GOTO,  8'h41, 8'h00, 8'(ROWS - 1), 0);
      issue(REQ_PUT,   8'h5A, 8'h7F, 8'h00, 0);
      issue(REQ_READ,  8'h00, 8'h00, 8'h00, (ROWS - 1) * COLS);
      // newline on the bottom row scrolls
      issue(REQ_PUT,   NEWLINE_CHAR, 8'hC3, 8'h00, 0);
      issue(REQ_READ,  8'h00, 8'h00, 8'h00, (ROWS - 2) * COLS);
      issue(REQ_READ,  8'h00, 8'h00, 8'h00, (ROWS - 1) * COLS);
      // go to line just past and far past the bottom
      issue(REQ_GOTO,  8'h00, 8'h81, 8'(ROWS), 0);
      issue(REQ_GOTO,  8'h00, 8'h42, 8'hFF, 0);
      issue(REQ_CLEAR, 8'h00, 8'h17, 8'h00, 0);
      issue(REQ_READ,  8'h00, 8'h00, 8'h00, 0);
      issue(REQ_READ,  8'h00, 8'h00, 8'h00, CELLS - 1);
      issue(REQ_CLEAR, 8'hFF, 8'hFF, 8'hFF, ADDR_MAX);
      issue(REQ_CLEAR, 8'h00, 8'h00, 8'h00, 0);
      issue(REQ_READ,  8'h00, 8'h00, 8'h00, 1234);
      wait_for_drain();

      run_phase(32, 56);
      run_phase(56, 32);
      // long response hold-off while requests keep coming
      hold_toggle <= ~hold_toggle;
      run_phase(0, 0);

      repeat (SETTLE_CYCLES) @(posedge clock);
      if (sb.expected_status.size() != 0)
         sb.report_mismatch($sformatf("%0d responses never arrived",
                                      sb.expected_status.size()));
      $display("covered %0d requests: %0d reads, %0d clears, %0d scrolls, %0d screen-full states",
               sb.request_count, sb.read_count, sb.clear_count, sb.scroll_count,
               sb.full_count);
      $display("checked %0d responses, %0d mismatches", sb.result_count, sb.error_count);
      if (sb.error_count == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule

>>> text_console_writer.f
+incdir+rtl
rtl/tcw_pkg.sv
rtl/tcw_screen_ram.sv
rtl/text_console_writer.sv
rtl/tcw_checker.sv
tb/text_console_writer_tb.sv
